// ===== sv/wsp_pkg.sv =====
`default_nettype none

package wsp_pkg;

	// Build defaults
	localparam int SCREEN_WIDTH_DEF  = 1024;
	localparam int SCREEN_HEIGHT_DEF = 768;
	localparam int ANGLE_BITS_DEF    = 16;

	// Configuration port
	localparam int AW = 6;
	localparam int DW = 64;

	localparam logic [2:0] REG_ZOOM     = 3'd0;
	localparam logic [2:0] REG_CENTER_X = 3'd1;
	localparam logic [2:0] REG_CENTER_Y = 3'd2;
	localparam logic [2:0] REG_ANGLE_X  = 3'd3;
	localparam logic [2:0] REG_ANGLE_Y  = 3'd4;
	localparam logic [2:0] REG_ANGLE_Z  = 3'd5;
	localparam logic [2:0] REG_MODE     = 3'd6;

	// Datapath widths
	localparam int FW    = 48;  // field width of a world coordinate
	localparam int CW    = 52;  // coordinate width through the rotations
	localparam int TW    = 32;  // signed Q30 sine / cosine
	localparam int PPH_W = 60;  // high partial product
	localparam int PPL_W = 57;  // low partial product
	localparam int UW    = 52;  // offset from view center
	localparam int MW    = 60;  // offset times 100
	localparam int PW    = 61;  // high part times zoom
	localparam int QW    = 45;  // unsaturated Q8 pixel value
	localparam int OW    = 32;  // screen field width

	localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam int SIN_TERMS = 5;
	localparam int COS_TERMS = 6;

	// Divisors of the nested Taylor series, innermost term first
	function automatic logic [7:0] trig_div(input logic cos_ph, input logic [2:0] term);
		logic [7:0] d;
		d = 8'd1;
		if (!cos_ph) begin
			case (term)
				3'd0: d = 8'd110;
				3'd1: d = 8'd72;
				3'd2: d = 8'd42;
				3'd3: d = 8'd20;
				3'd4: d = 8'd6;
				default: d = 8'd1;
			endcase
		end else begin
			case (term)
				3'd0: d = 8'd132;
				3'd1: d = 8'd90;
				3'd2: d = 8'd56;
				3'd3: d = 8'd30;
				3'd4: d = 8'd12;
				3'd5: d = 8'd2;
				default: d = 8'd1;
			endcase
		end
		return d;
	endfunction

	// floor(2^32 / divisor); the estimate it gives is low by at most one
	function automatic logic [31:0] trig_rcp(input logic cos_ph, input logic [2:0] term);
		logic [31:0] m;
		m = 32'hFFFF_FFFF;
		if (!cos_ph) begin
			case (term)
				3'd0: m = 32'd39045157;
				3'd1: m = 32'd59652323;
				3'd2: m = 32'd102261126;
				3'd3: m = 32'd214748364;
				3'd4: m = 32'd715827882;
				default: m = 32'hFFFF_FFFF;
			endcase
		end else begin
			case (term)
				3'd0: m = 32'd32537631;
				3'd1: m = 32'd47721858;
				3'd2: m = 32'd76695844;
				3'd3: m = 32'd143165576;
				3'd4: m = 32'd357913941;
				3'd5: m = 32'd2147483648;
				default: m = 32'hFFFF_FFFF;
			endcase
		end
		return m;
	endfunction

	// One long-division digit by 5 via reciprocal; v below 5*2^18.
	// Returns {quotient[17:0], remainder[2:0]}.
	function automatic logic [20:0] div5_step(input logic [20:0] v);
		logic [41:0] pr;
		logic [17:0] q;
		logic [20:0] r;
		pr = 42'(v) * 42'd1677722;
		q  = pr[40:23];
		r  = v - (21'(q) << 2) - 21'(q);
		return {q, r[2:0]};
	endfunction

	// floor((ph*2^24 + pl) / 2^30)
	function automatic logic signed [CW-1:0] mul_join(input logic signed [PPH_W-1:0] ph,
			input logic signed [PPL_W-1:0] pl);
		logic signed [83:0] f;
		f = $signed({ph, 24'd0}) + 84'(pl);
		return f[30+CW-1:30];
	endfunction

	// Saturate to signed 32 bits
	function automatic logic [OW-1:0] sat32(input logic signed [QW:0] v);
		logic [OW-1:0] r;
		if (v > $signed((QW+1)'(32'h7FFF_FFFF)))
			r = 32'h7FFF_FFFF;
		else if (v < -$signed((QW+1)'(33'h0_8000_0000)))
			r = 32'h8000_0000;
		else
			r = v[OW-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/wsp_trig.sv =====
`default_nettype none

module wsp_trig #(
	parameter int ANGLE_BITS = wsp_pkg::ANGLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [15:0]                    angle   [3],
	output logic signed [wsp_pkg::TW-1:0]  sin_val [3],
	output logic signed [wsp_pkg::TW-1:0]  cos_val [3],
	output logic                           ready
);
	import wsp_pkg::*;

	localparam int DROP = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
	localparam logic [15:0] AMASK = 16'(17'h1FFFF << DROP);

	localparam logic [3:0] T_IDLE  = 4'd0;
	localparam logic [3:0] T_X     = 4'd1;
	localparam logic [3:0] T_X2    = 4'd2;
	localparam logic [3:0] T_MUL   = 4'd3;
	localparam logic [3:0] T_RCP   = 4'd4;
	localparam logic [3:0] T_DIV   = 4'd5;
	localparam logic [3:0] T_FIX   = 4'd6;
	localparam logic [3:0] T_SIN   = 4'd7;
	localparam logic [3:0] T_STORE = 4'd8;

	logic [3:0]  st_q;
	logic [1:0]  idx_q;
	logic [31:0] x_q, x2_q, s_q;
	logic [30:0] t_q;
	logic [31:0] dvd_q, quo_q;
	logic [8:0]  rem_q;
	logic [2:0]  term_q;
	logic        cos_ph_q;

	logic [15:0] am;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [7:0]  dv;
	logic [31:0] rcp;
	logic [31:0] diff;
	logic [31:0] quo_n;
	logic [30:0] t_next;
	logic [2:0]  last_term;
	logic signed [TW-1:0] s_sg, c_sg;

	assign am    = angle[idx_q] & AMASK;
	assign ready = (st_q == T_IDLE);

	// Shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			T_X: begin
				mul_a = {18'd0, am[13:0]};
				mul_b = HALF_PI_Q30;
			end
			T_X2: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			T_MUL: begin
				mul_a = x2_q;
				mul_b = {1'b0, t_q};
			end
			T_RCP: begin
				mul_a = dvd_q;
				mul_b = rcp;
			end
			T_DIV: begin
				mul_a = quo_q;
				mul_b = {24'd0, dv};
			end
			T_SIN: begin
				mul_a = x_q;
				mul_b = {1'b0, t_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = 64'(mul_a) * 64'(mul_b);

	// Division by the series constant: reciprocal estimate, then one correction
	assign dv    = trig_div(cos_ph_q, term_q);
	assign rcp   = trig_rcp(cos_ph_q, term_q);
	assign diff  = dvd_q - prod[31:0];
	assign quo_n = (rem_q >= {1'b0, dv}) ? quo_q + 32'd1 : quo_q;

	always_comb begin
		if (!cos_ph_q)
			t_next = 31'(Q30_ONE - quo_n);
		else if (quo_n >= Q30_ONE)
			t_next = '0;
		else
			t_next = 31'(Q30_ONE - quo_n);
	end
	assign last_term = cos_ph_q ? 3'(COS_TERMS - 1) : 3'(SIN_TERMS - 1);

	assign s_sg = $signed(s_q);
	assign c_sg = $signed({1'b0, t_q});

	// Sequencer: x, x^2, sine series, cosine series, quadrant fold, per angle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= T_IDLE;
			idx_q    <= '0;
			term_q   <= '0;
			cos_ph_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				sin_val[i] <= '0;
				cos_val[i] <= $signed(Q30_ONE);
			end
		end else if (start) begin
			st_q  <= T_X;
			idx_q <= '0;
		end else begin
			case (st_q)
				T_X: st_q <= T_X2;
				T_X2: begin
					st_q     <= T_MUL;
					term_q   <= '0;
					cos_ph_q <= 1'b0;
				end
				T_MUL: st_q <= T_RCP;
				T_RCP: st_q <= T_DIV;
				T_DIV: st_q <= T_FIX;
				T_FIX: begin
					if (term_q == last_term)
						st_q <= cos_ph_q ? T_STORE : T_SIN;
					else
						st_q <= T_MUL;
					term_q <= term_q + 3'd1;
				end
				T_SIN: begin
					st_q     <= T_MUL;
					cos_ph_q <= 1'b1;
					term_q   <= '0;
				end
				T_STORE: begin
					case (am[15:14])
						2'd0: begin
							sin_val[idx_q] <= s_sg;
							cos_val[idx_q] <= c_sg;
						end
						2'd1: begin
							sin_val[idx_q] <= c_sg;
							cos_val[idx_q] <= -s_sg;
						end
						2'd2: begin
							sin_val[idx_q] <= -s_sg;
							cos_val[idx_q] <= -c_sg;
						end
						default: begin
							sin_val[idx_q] <= -c_sg;
							cos_val[idx_q] <= s_sg;
						end
					endcase
					if (idx_q == 2'd2) begin
						st_q <= T_IDLE;
					end else begin
						idx_q <= idx_q + 2'd1;
						st_q  <= T_X;
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (st_q)
			T_X: x_q <= prod[45:14];
			T_X2: begin
				x2_q <= prod[61:30];
				t_q  <= Q30_ONE[30:0];
			end
			T_MUL: dvd_q <= prod[61:30];
			T_RCP: quo_q <= prod[63:32];
			T_DIV: rem_q <= diff[8:0];
			T_FIX: t_q <= t_next;
			T_SIN: begin
				s_q <= prod[61:30];
				t_q <= Q30_ONE[30:0];
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/world_to_screen_projection.sv =====
// World to screen projection. Takes one world point per cycle on the input stream
// (x, y, z in AU, signed Q32) and returns its screen position in pixels (signed Q8,
// saturated) through fifteen register stages; full rate is one point per clock, and
// a stall on the output holds every stage in place. Registers sit on the APB-style
// port at 8-byte steps. Writing any angle register starts a recomputation of all
// three sine/cosine pairs on a shared multiplier, dividing by the series constants
// through reciprocals, and the input stream is held off (s_axis_tready low) until
// it is done. With 3D mode off, world_z is ignored and no rotation is applied.
`default_nettype none

module world_to_screen_projection #(
	parameter int SCREEN_WIDTH  = wsp_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = wsp_pkg::SCREEN_HEIGHT_DEF,
	parameter int ANGLE_BITS    = wsp_pkg::ANGLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [wsp_pkg::AW-1:0] paddr,
	input  logic [wsp_pkg::DW-1:0] pwdata,
	output logic [wsp_pkg::DW-1:0] prdata,
	output logic                   pready,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [143:0]           s_axis_tdata,  // world_x, world_y, world_z
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [63:0]            m_axis_tdata   // screen_x, screen_y
);
	import wsp_pkg::*;

	localparam logic signed [QW:0] OFF_X = (QW+1)'(SCREEN_WIDTH * 128);
	localparam logic signed [QW:0] OFF_Y = (QW+1)'(SCREEN_HEIGHT * 128);
	localparam logic [55:0] W_BIAS  = 56'd5 << 50;
	localparam logic [54:0] D5_BIAS = 55'd1 << 50;

	// Configuration registers
	logic [23:0]          zoom_q;
	logic signed [FW-1:0] center_x_q, center_y_q;
	logic [15:0]          angle_q [3];
	logic                 three_d_q;

	logic       cfg_wr, trig_start, trig_rdy;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[5:3];
	assign cfg_wr  = psel && penable && pwrite;
	assign trig_start = cfg_wr && (cfg_idx == REG_ANGLE_X || cfg_idx == REG_ANGLE_Y ||
		cfg_idx == REG_ANGLE_Z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_q     <= 24'h01_0000;
			center_x_q <= '0;
			center_y_q <= '0;
			angle_q[0] <= '0;
			angle_q[1] <= '0;
			angle_q[2] <= '0;
			three_d_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ZOOM:     zoom_q     <= pwdata[23:0];
				REG_CENTER_X: center_x_q <= $signed(pwdata[FW-1:0]);
				REG_CENTER_Y: center_y_q <= $signed(pwdata[FW-1:0]);
				REG_ANGLE_X:  angle_q[0] <= pwdata[15:0];
				REG_ANGLE_Y:  angle_q[1] <= pwdata[15:0];
				REG_ANGLE_Z:  angle_q[2] <= pwdata[15:0];
				REG_MODE:     three_d_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (cfg_idx)
			REG_ZOOM:     prdata = DW'(zoom_q);
			REG_CENTER_X: prdata = DW'(center_x_q);
			REG_CENTER_Y: prdata = DW'(center_y_q);
			REG_ANGLE_X:  prdata = DW'(angle_q[0]);
			REG_ANGLE_Y:  prdata = DW'(angle_q[1]);
			REG_ANGLE_Z:  prdata = DW'(angle_q[2]);
			REG_MODE:     prdata = DW'(three_d_q);
			default:      prdata = '0;
		endcase
	end

	// Sine / cosine of the three angles
	logic signed [TW-1:0] sin_val [3];
	logic signed [TW-1:0] cos_val [3];
	logic signed [TW-1:0] sin_e [3];
	logic signed [TW-1:0] cos_e [3];

	wsp_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (trig_start),
		.angle   (angle_q),
		.sin_val (sin_val),
		.cos_val (cos_val),
		.ready   (trig_rdy)
	);

	// Top view: identity rotation
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sin_e[i] = three_d_q ? sin_val[i] : '0;
			cos_e[i] = three_d_q ? cos_val[i] : $signed(Q30_ONE);
		end
	end

	// Pipeline control: one global enable, valid bit per stage
	logic [15:1] vld_s;
	logic        en, acc_in;

	assign en            = !vld_s[15] || m_axis_tready;
	assign s_axis_tready = en && trig_rdy;
	assign acc_in        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[14:1], acc_in};
	end

	// Coordinates at rotation boundaries: [0] stage 1, [1] stage 4,
	// [2] stage 7, [3] stage 10
	logic signed [CW-1:0] crd_s [4][3];

	always_ff @(posedge clk) begin
		if (en) begin
			crd_s[0][0] <= CW'($signed(s_axis_tdata[47:0]));
			crd_s[0][1] <= CW'($signed(s_axis_tdata[95:48]));
			crd_s[0][2] <= CW'($signed(s_axis_tdata[143:96]));
		end
	end

	// Rotations about X, Y, Z: (a, b) -> (a*c - b*s, a*s + b*c)
	for (genvar r = 0; r < 3; r++) begin : g_rot
		localparam int IA = (r == 0) ? 1 : ((r == 1) ? 2 : 0);
		localparam int IB = (r == 0) ? 2 : ((r == 1) ? 0 : 1);
		localparam int IC = (r == 0) ? 0 : ((r == 1) ? 1 : 2);

		logic signed [27:0]       hi_a, hi_b;
		logic signed [24:0]       lo_a, lo_b;
		logic signed [PPH_W-1:0]  pph_sa [4];
		logic signed [PPL_W-1:0]  ppl_sa [4];
		logic signed [CW-1:0]     pass_sa, pass_sb;
		logic signed [CW-1:0]     prod_sb [4];

		assign hi_a = $signed(crd_s[r][IA][CW-1:24]);
		assign hi_b = $signed(crd_s[r][IB][CW-1:24]);
		assign lo_a = $signed({1'b0, crd_s[r][IA][23:0]});
		assign lo_b = $signed({1'b0, crd_s[r][IB][23:0]});

		always_ff @(posedge clk) begin
			if (en) begin
				// partial products
				pph_sa[0] <= hi_a * cos_e[r];
				ppl_sa[0] <= lo_a * cos_e[r];
				pph_sa[1] <= hi_b * sin_e[r];
				ppl_sa[1] <= lo_b * sin_e[r];
				pph_sa[2] <= hi_a * sin_e[r];
				ppl_sa[2] <= lo_a * sin_e[r];
				pph_sa[3] <= hi_b * cos_e[r];
				ppl_sa[3] <= lo_b * cos_e[r];
				pass_sa   <= crd_s[r][IC];
				// floored Q30 products
				for (int k = 0; k < 4; k++)
					prod_sb[k] <= mul_join(pph_sa[k], ppl_sa[k]);
				pass_sb <= pass_sa;
				// rotated pair
				crd_s[r+1][IA] <= prod_sb[0] - prod_sb[1];
				crd_s[r+1][IB] <= prod_sb[2] + prod_sb[3];
				crd_s[r+1][IC] <= pass_sb;
			end
		end
	end

	// floor(4z/5) by long division in three digits, alongside the Z rotation
	logic [55:0] wz;
	logic [20:0] d1, d2, d3;
	logic [17:0] dq1_s8, dq1_s9, dq2_s9;
	logic [2:0]  dr1_s8, dr2_s9;
	logic [35:0] wlo_s8;
	logic [17:0] wlo_s9;
	logic [52:0] quo_s10;

	assign wz = 56'($signed({crd_s[2][2], 2'b00})) + W_BIAS;
	assign d1 = div5_step(21'(wz[52:36]));
	assign d2 = div5_step({dr1_s8, wlo_s8[35:18]});
	assign d3 = div5_step({dr2_s9, wlo_s9});

	always_ff @(posedge clk) begin
		if (en) begin
			dq1_s8  <= d1[20:3];
			dr1_s8  <= d1[2:0];
			wlo_s8  <= wz[35:0];
			dq1_s9  <= dq1_s8;
			dq2_s9  <= d2[20:3];
			dr2_s9  <= d2[2:0];
			wlo_s9  <= wlo_s8[17:0];
			quo_s10 <= {dq1_s9[16:0], dq2_s9, d3[20:3]};
		end
	end

	// Offsets, scaling, screen center, saturation
	logic signed [CW-1:0]  zh;
	logic signed [54:0]    d5;
	logic signed [53:0]    ux_w, uy_w;
	logic signed [UW-1:0]  ux_s11, uy_s11;
	logic signed [MW-1:0]  mx_s12, my_s12;
	logic signed [PW-1:0]  phx_s13, phy_s13;
	logic [47:0]           plx_s13, ply_s13;
	logic signed [PW-1:0]  sumx, sumy;
	logic signed [QW-1:0]  qx_s14, qy_s14;
	logic [OW-1:0]         sx_s15, sy_s15;
	logic signed [24:0]    zoom_sg;

	assign zh = crd_s[3][2] >>> 1;
	assign d5 = $signed(55'(quo_s10) - D5_BIAS);
	assign ux_w = 54'(crd_s[3][0]) - 54'(center_x_q) - (three_d_q ? 54'(zh) : 54'sd0);
	assign uy_w = 54'(crd_s[3][1]) - 54'(center_y_q) - (three_d_q ? 54'(d5) : 54'sd0);
	assign zoom_sg = $signed({1'b0, zoom_q});
	assign sumx = phx_s13 + $signed(PW'(plx_s13[47:24]));
	assign sumy = phy_s13 + $signed(PW'(ply_s13[47:24]));

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s11  <= UW'(ux_w);
			uy_s11  <= UW'(uy_w);
			mx_s12  <= (MW'(ux_s11) <<< 6) + (MW'(ux_s11) <<< 5) + (MW'(ux_s11) <<< 2);
			my_s12  <= (MW'(uy_s11) <<< 6) + (MW'(uy_s11) <<< 5) + (MW'(uy_s11) <<< 2);
			phx_s13 <= $signed(mx_s12[MW-1:24]) * zoom_sg;
			phy_s13 <= $signed(my_s12[MW-1:24]) * zoom_sg;
			plx_s13 <= 48'(mx_s12[23:0]) * 48'(zoom_q);
			ply_s13 <= 48'(my_s12[23:0]) * 48'(zoom_q);
			qx_s14  <= sumx[PW-1:16];
			qy_s14  <= sumy[PW-1:16];
			sx_s15  <= sat32((QW+1)'(qx_s14) + OFF_X);
			sy_s15  <= sat32((QW+1)'(qy_s14) + OFF_Y);
		end
	end

	assign m_axis_tvalid = vld_s[15];
	assign m_axis_tdata  = {sy_s15, sx_s15};

endmodule

`default_nettype wire

// ===== sv/wsp_checker.sv =====
`default_nettype none

module wsp_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   psel,
	input logic                   penable,
	input logic                   pwrite,
	input logic [wsp_pkg::AW-1:0] paddr,
	input logic                   pready,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [63:0]            m_axis_tdata
);
	import wsp_pkg::*;

	logic angle_wr;
	assign angle_wr = psel && penable && pwrite && pready &&
		(paddr[5:3] == REG_ANGLE_X || paddr[5:3] == REG_ANGLE_Y ||
		paddr[5:3] == REG_ANGLE_Z);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// A full pipeline under stall takes no new request
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("request taken while output stalled");

	// New angles hold off requests until sine/cosine are recomputed
	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		angle_wr |=> !s_axis_tready)
		else $error("request taken during angle update");

endmodule

bind world_to_screen_projection wsp_checker u_wsp_checker (.*);

`default_nettype wire

// ===== tb/world_to_screen_projection_test.sv =====
`timescale 1ns / 100ps

module world_to_screen_projection_test;
	import wsp_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam longint HALF_PI = 64'd1686629713;

	typedef struct packed {
		logic [31:0] sy;
		logic [31:0] sx;
	} screen_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [AW-1:0] paddr = '0;
	logic [DW-1:0] pwdata = '0;
	logic [DW-1:0] prdata;
	logic pready;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [143:0] s_axis_tdata = '0;  // world_x, world_y, world_z
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;        // screen_x, screen_y

	// shadow of the register file
	logic [23:0] zoom_r = 24'd65536;
	longint cx_r = 0, cy_r = 0;
	logic [15:0] ax_r = '0, ay_r = '0, az_r = '0;
	logic mode_r = 1'b0;

	logic [143:0] point_q[$];
	screen_t screen_q[$];
	int offered = 0, accepted = 0;
	int burst_left = 0, gap_left = 0;
	int hold_req = 0, hold_seen = 0, hold_left = 0;
	int rx_mode = 0;
	int cycles = 0;
	bit failed = 0;

	world_to_screen_projection dut (.*);

	always #10 clk = ~clk;

	function automatic longint sext48(input logic [47:0] v);
		return longint'($signed(v));
	endfunction

	// floor(v * s / 2^30)
	function automatic longint mul_trig(input longint v, input longint s);
		longint a, b, lo;
		a = (v >>> 24) * s;
		b = longint'(v & 64'hFFFFFF) * s;
		lo = (longint'(a & 64'd63) <<< 24) + b;
		return (a >>> 6) + (lo >>> 30);
	endfunction

	// Q30 sine and cosine from nested Taylor series, quadrant folded
	task automatic trig(input logic [15:0] ang, output longint s_o, output longint c_o);
		logic [63:0] sdiv[5];
		logic [63:0] cdiv[6];
		logic [63:0] r, x, x2, t, p;
		longint s, c;
		logic [1:0] quad;
		sdiv = '{110, 72, 42, 20, 6};
		cdiv = '{132, 90, 56, 30, 12, 2};
		quad = ang[15:14];
		r = {50'd0, ang[13:0]};
		x = (r * HALF_PI) >> 14;
		x2 = (x * x) >> 30;
		t = 64'd1 << 30;
		for (int i = 0; i < 5; i++)
			t = (64'd1 << 30) - ((x2 * t) >> 30) / sdiv[i];
		s = longint'((x * t) >> 30);
		t = 64'd1 << 30;
		for (int i = 0; i < 6; i++) begin
			p = ((x2 * t) >> 30) / cdiv[i];
			t = (p >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - p;
		end
		c = longint'(t);
		case (quad)
			2'd0: begin s_o = s; c_o = c; end
			2'd1: begin s_o = c; c_o = -s; end
			2'd2: begin s_o = -s; c_o = -c; end
			default: begin s_o = -c; c_o = s; end
		endcase
	endtask

	// pixels in Q8: floor(u * 100 * zoom / 2^40)
	function automatic longint to_pixels(input longint u);
		longint m, hi, acc;
		logic [63:0] low;
		m = u * 100;
		hi = m >>> 24;
		low = m & 64'hFFFFFF;
		acc = hi * longint'({40'd0, zoom_r}) + longint'((low * {40'd0, zoom_r}) >> 24);
		return acc >>> 16;
	endfunction

	function automatic longint div5_floor(input longint q);
		if (q >= 0)
			return q / 5;
		return -((-q + 4) / 5);
	endfunction

	function automatic logic [31:0] clip32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	task automatic project(input logic [143:0] pt, output screen_t res);
		longint x, y, z, s, c, nx, ny, nz, ux, uy;
		x = sext48(pt[47:0]);
		y = sext48(pt[95:48]);
		z = sext48(pt[143:96]);
		if (mode_r) begin
			trig(ax_r, s, c);
			ny = mul_trig(y, c) - mul_trig(z, s);
			nz = mul_trig(y, s) + mul_trig(z, c);
			y = ny; z = nz;
			trig(ay_r, s, c);
			nx = mul_trig(x, c) + mul_trig(z, s);
			nz = mul_trig(z, c) - mul_trig(x, s);
			x = nx; z = nz;
			trig(az_r, s, c);
			nx = mul_trig(x, c) - mul_trig(y, s);
			ny = mul_trig(x, s) + mul_trig(y, c);
			x = nx; y = ny;
			ux = x - cx_r - (z >>> 1);
			uy = y - cy_r - div5_floor(z * 4);
		end else begin
			ux = x - cx_r;
			uy = y - cy_r;
		end
		res.sx = clip32(to_pixels(ux) + 1024 * 128);
		res.sy = clip32(to_pixels(uy) + 768 * 128);
	endtask

	// register write over the config port, shadow follows
	task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 3'b000}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_ZOOM: zoom_r = val[23:0];
			REG_CENTER_X: cx_r = sext48(val[47:0]);
			REG_CENTER_Y: cy_r = sext48(val[47:0]);
			REG_ANGLE_X: ax_r = val[15:0];
			REG_ANGLE_Y: ay_r = val[15:0];
			REG_ANGLE_Z: az_r = val[15:0];
			REG_MODE: mode_r = val[0];
			default: ;
		endcase
	endtask

	task automatic set_view(input logic [23:0] zm, input logic [47:0] cx, input logic [47:0] cy,
			input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az, input logic md);
		reg_write(REG_ZOOM, {40'd0, zm});
		reg_write(REG_CENTER_X, {16'd0, cx});
		reg_write(REG_CENTER_Y, {16'd0, cy});
		reg_write(REG_ANGLE_X, {48'd0, ax});
		reg_write(REG_ANGLE_Y, {48'd0, ay});
		reg_write(REG_ANGLE_Z, {48'd0, az});
		reg_write(REG_MODE, {63'd0, md});
	endtask

	// sender pauses until every request has come back
	task automatic drain;
		while (point_q.size() != 0 || s_axis_tvalid || screen_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [47:0] rand_coord;
		logic [47:0] v;
		v = 48'({$urandom, $urandom});
		return 48'($signed(v) >>> $urandom_range(0, 40));
	endfunction

	function automatic logic [143:0] rand_point;
		return {rand_coord(), rand_coord(), rand_coord()};
	endfunction

	task automatic push_random(input int n);
		repeat (n) point_q.push_back(rand_point());
	endtask

	// driver: bursts of requests with random gaps
	always @(negedge clk) begin
		if (!s_axis_tvalid || accepted == offered) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (point_q.size() != 0) begin
				s_axis_tdata <= point_q.pop_front();
				s_axis_tvalid <= 1'b1;
				offered <= offered + 1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// predict at each accepted request
	always @(posedge clk) begin
		screen_t e;
		if (s_axis_tvalid && s_axis_tready) begin
			project(s_axis_tdata, e);
			screen_q.push_back(e);
			accepted <= accepted + 1;
		end
	end

	// receiver: stall pattern picked at random from three modes, plus one long hold-off
	always @(negedge clk) begin
		if (cycles % 64 == 0)
			rx_mode <= $urandom_range(0, 2);
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 400;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// monitor: compare each result with the oldest prediction
	always @(posedge clk) begin
		screen_t e, got;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (screen_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				failed = 1;
			end else begin
				e = screen_q.pop_front();
				if (got.sx !== e.sx) begin
					$display("%0t: screen_x expected %h actual %h", $time, e.sx, got.sx);
					failed = 1;
				end
				if (got.sy !== e.sy) begin
					$display("%0t: screen_y expected %h actual %h", $time, e.sy, got.sy);
					failed = 1;
				end
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// top view at reset values: field extremes, z ignored
		point_q.push_back('0);
		point_q.push_back({48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF});
		point_q.push_back({48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000});
		point_q.push_back({48'h1234_0000_0000, 48'h0000_1_0000_000, 48'hFFFF_0_0000_000});
		point_q.push_back({48'hFFFF_FFFF_FFFF, 48'h0000_0000_0001, 48'hFFFF_FFFF_FFFF});
		point_q.push_back({48'h0003_0000_0000, 48'hFFFE_0000_0000, 48'h0002_0000_0000});
		drain();

		// zero angles in 3D mode: only depth term; extreme centers, smallest nonzero zoom
		set_view(24'd1, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 16'd0, 16'd0, 16'd0, 1'b1);
		reg_write(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		point_q.push_back('0);
		point_q.push_back({48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF});
		point_q.push_back({48'h0001_0000_0000, 48'h0002_0000_0000, 48'hFFFF_0000_0000});
		drain();

		// zoom of zero lands on screen center
		set_view(24'd0, 48'h0, 48'h0, 16'd16384, 16'd32768, 16'd49152, 1'b1);
		point_q.push_back(rand_point());
		point_q.push_back({48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000});
		push_random(100);
		drain();

		// largest zoom and angles, overflow saturation
		set_view(24'hFF_FFFF, 48'h0, 48'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		point_q.push_back({48'h0000_0000_0001, 48'h0000_0000_0001, 48'h0000_0000_0001});
		point_q.push_back({48'h0100_0000_0000, 48'hFF00_0000_0000, 48'h0100_0000_0000});
		push_random(150);
		drain();

		// random views, one with a long receiver hold-off
		for (int ph = 0; ph < 8; ph++) begin
			set_view(24'($urandom_range(1, 24'h3_0000)),
				{{12{1'b0}}, 36'($urandom)} - 48'h8_0000_0000,
				{{12{1'b0}}, 36'($urandom)} - 48'h8_0000_0000, 16'($urandom),
				16'($urandom), 16'($urandom), (ph % 3) != 2);
			if (ph == 2)
				hold_req = hold_req + 1;
			push_random(180);
			drain();
		end

		// back to top view with a random center
		set_view(24'($urandom_range(1, 24'hFF_FFFF)), rand_coord(), rand_coord(), 16'd0,
			16'd0, 16'd0, 1'b0);
		push_random(100);
		drain();

		repeat (40) @(posedge clk);
		if (!failed)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
